>>> hdl/cansd_pkg.sv
package cansd_pkg;

  // Item kinds as they arrive on the input channel.
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Parameter groups that the decoder knows.
  localparam logic [15:0] PGN_TACHO   = 16'hFE6C;
  localparam logic [15:0] PGN_WHEEL   = 16'hFEF1;
  localparam logic [15:0] PGN_ENGINE  = 16'hF004;
  localparam logic [15:0] PGN_BRAKE   = 16'hF001;
  localparam logic [15:0] PGN_ACCEL   = 16'hF003;
  localparam logic [15:0] PGN_DIST    = 16'hFEE0;
  localparam logic [15:0] PGN_VDIST   = 16'hFEC1;
  localparam logic [15:0] PGN_FUEL    = 16'hFEE9;
  localparam logic [15:0] PGN_AMBIENT = 16'hFE6F;
  localparam logic [15:0] PGN_HRDIST  = 16'hFEC3;
  localparam logic [15:0] PGN_IDLE    = 16'hFEE8;
  localparam logic [15:0] PGN_TEMP    = 16'hFEEA;
  localparam logic [15:0] PGN_SILENT  = 16'hF000;

  // Slot of a known group; for every group but the silent one it equals the number of its staleness counter.
  localparam int unsigned SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_TACHO   = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_WHEEL   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_ENGINE  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_BRAKE   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_ACCEL   = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_DIST    = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_VDIST   = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_FUEL    = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_AMBIENT = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_HRDIST  = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_IDLE    = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_TEMP    = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_SILENT  = 4'd12;

  localparam int unsigned NUM_CNT = 12;
  localparam int unsigned NUM_LONG = 6;
  localparam int unsigned NUM_SHORT = 6;

  // Read indexes.
  localparam logic [4:0] RD_SPEED       = 5'd0;
  localparam logic [4:0] RD_DIRECTION   = 5'd1;
  localparam logic [4:0] RD_RPM         = 5'd2;
  localparam logic [4:0] RD_BRAKE       = 5'd3;
  localparam logic [4:0] RD_ACCEL       = 5'd4;
  localparam logic [4:0] RD_VALID       = 5'd5;
  localparam logic [4:0] RD_LONG_FIRST  = 5'd6;
  localparam logic [4:0] RD_LONG_LAST   = 5'd11;
  localparam logic [4:0] RD_SHORT_FIRST = 5'd12;
  localparam logic [4:0] RD_SHORT_LAST  = 5'd17;

  // Speed valid bit patterns.
  localparam logic [1:0] SPD_TACHO_ONLY = 2'b01;
  localparam logic [1:0] SPD_WHEEL_ONLY = 2'b10;

  // Configuration registers.
  localparam logic CFG_SHORT = 1'b0;
  localparam logic CFG_LONG  = 1'b1;
  localparam logic [7:0] SHORT_TIMEOUT_RST = 8'd10;
  localparam logic [7:0] LONG_TIMEOUT_RST  = 8'd30;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FRAME,
    OP_UNKNOWN,
    OP_TICK,
    OP_READ
  } op_e;

  // One classified transaction on its way from front to back.
  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       payload;
    logic [4:0]        sig_index;
  } cmd_t;

  // Counters of the distance and fuel groups run against the long limit.
  function automatic logic uses_long_limit(input logic [SLOT_W-1:0] c);
    return (c == SLOT_DIST) || (c == SLOT_VDIST) || (c == SLOT_FUEL);
  endfunction

endpackage

>>> hdl/can_signal_decoder_with_timeouts.sv
// Decoder of vehicle-bus parameter groups with staleness timeouts.
// Input channel (in_valid_i / in_stall_o): one transaction is a received
// extended frame, a timer tick or a read of one stored signal, chosen by
// kind_i. Output channel (out_valid_o / out_stall_i): exactly one result per
// input transaction, in order: unknown_group_o flags an undecoded group and
// read_value_o carries the selected signal for a read, zero otherwise.
// A transaction passes through the queue and then the output register.
// Throughput is one transaction per cycle while the receiver does not stall:
// the classifier feeds a small queue and the executing stage drains one entry
// per cycle into the output register. When the receiver stalls, the result
// holds on the output and the queue fills; in_stall_o rises once the queue
// is full and falls after the first cycle without an output stall. The two
// timeout limits sit behind the APB port at byte addresses 0 and 4; the user
// must see that they are written only while the block is idle, as the block
// does not enforce this. Reset clears the queue, the staleness counters and
// the speed valid bits, sets every signal register to all ones and loads the
// timeouts with 10 and 30 ticks. No clearing pass.
module can_signal_decoder_with_timeouts #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [28:0] ext_id_i,
  input  logic [63:0] payload_i,
  input  logic [4:0]  signal_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        unknown_group_o,
  output logic [31:0] read_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cansd_pkg::cmd_t front_cmd;
  cansd_pkg::cmd_t queue_cmd;
  logic            queue_valid;
  logic            queue_pop;
  logic [7:0]      short_timeout_q;
  logic [7:0]      long_timeout_q;
  logic            cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_timeout_q <= cansd_pkg::SHORT_TIMEOUT_RST;
      long_timeout_q  <= cansd_pkg::LONG_TIMEOUT_RST;
    end else if (cfg_write) begin
      if (paddr[2] == cansd_pkg::CFG_LONG) begin
        long_timeout_q <= pwdata[7:0];
      end else begin
        short_timeout_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == cansd_pkg::CFG_SHORT) ? {24'd0, short_timeout_q}
                                                     : {24'd0, long_timeout_q};

  cansd_front u_front (
    .kind_i         (kind_i),
    .ext_id_i       (ext_id_i),
    .payload_i      (payload_i),
    .signal_index_i (signal_index_i),
    .cmd_o          (front_cmd)
  );

  cansd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop),
    .pop_cmd_o    (queue_cmd)
  );

  cansd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_i           (queue_cmd),
    .cmd_pop_o       (queue_pop),
    .short_timeout_i (short_timeout_q),
    .long_timeout_i  (long_timeout_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .unknown_group_o (unknown_group_o),
    .read_value_o    (read_value_o)
  );

endmodule

>>> hdl/cansd_front.sv
module cansd_front (
  input  logic [1:0]          kind_i,
  input  logic [28:0]         ext_id_i,
  input  logic [63:0]         payload_i,
  input  logic [4:0]          signal_index_i,
  output cansd_pkg::cmd_t     cmd_o
);

  logic [15:0] pgn;

  assign pgn = ext_id_i[23:8];

  // Classify the transaction and map a known group onto its slot.
  always_comb begin
    cmd_o.op        = cansd_pkg::OP_NOP;
    cmd_o.slot      = cansd_pkg::SLOT_SILENT;
    cmd_o.payload   = payload_i;
    cmd_o.sig_index = signal_index_i;
    case (kind_i)
      cansd_pkg::KIND_FRAME: begin
        cmd_o.op = cansd_pkg::OP_FRAME;
        case (pgn)
          cansd_pkg::PGN_TACHO:   cmd_o.slot = cansd_pkg::SLOT_TACHO;
          cansd_pkg::PGN_WHEEL:   cmd_o.slot = cansd_pkg::SLOT_WHEEL;
          cansd_pkg::PGN_ENGINE:  cmd_o.slot = cansd_pkg::SLOT_ENGINE;
          cansd_pkg::PGN_BRAKE:   cmd_o.slot = cansd_pkg::SLOT_BRAKE;
          cansd_pkg::PGN_ACCEL:   cmd_o.slot = cansd_pkg::SLOT_ACCEL;
          cansd_pkg::PGN_DIST:    cmd_o.slot = cansd_pkg::SLOT_DIST;
          cansd_pkg::PGN_VDIST:   cmd_o.slot = cansd_pkg::SLOT_VDIST;
          cansd_pkg::PGN_FUEL:    cmd_o.slot = cansd_pkg::SLOT_FUEL;
          cansd_pkg::PGN_AMBIENT: cmd_o.slot = cansd_pkg::SLOT_AMBIENT;
          cansd_pkg::PGN_HRDIST:  cmd_o.slot = cansd_pkg::SLOT_HRDIST;
          cansd_pkg::PGN_IDLE:    cmd_o.slot = cansd_pkg::SLOT_IDLE;
          cansd_pkg::PGN_TEMP:    cmd_o.slot = cansd_pkg::SLOT_TEMP;
          cansd_pkg::PGN_SILENT:  cmd_o.slot = cansd_pkg::SLOT_SILENT;
          default:                cmd_o.op   = cansd_pkg::OP_UNKNOWN;
        endcase
      end
      cansd_pkg::KIND_TICK: cmd_o.op = cansd_pkg::OP_TICK;
      cansd_pkg::KIND_READ: cmd_o.op = cansd_pkg::OP_READ;
      default:              cmd_o.op = cansd_pkg::OP_NOP;
    endcase
  end

endmodule

>>> hdl/cansd_fifo.sv
module cansd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_stall_o,
  input  cansd_pkg::cmd_t push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output cansd_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cansd_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_stall_o = (count_q == FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/cansd_back.sv
module cansd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  cansd_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  logic [7:0]      short_timeout_i,
  input  logic [7:0]      long_timeout_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            unknown_group_o,
  output logic [31:0]     read_value_o
);

  localparam int unsigned NumCnt   = cansd_pkg::NUM_CNT;
  localparam int unsigned NumLong  = cansd_pkg::NUM_LONG;
  localparam int unsigned NumShort = cansd_pkg::NUM_SHORT;
  localparam int unsigned SlotW    = cansd_pkg::SLOT_W;

  logic        go, do_frame, do_tick;
  logic [63:0] p;
  logic [cansd_pkg::SLOT_W-1:0] slot;

  logic [7:0]  cnt_q [NumCnt];
  logic [7:0]  cnt_d [NumCnt];
  logic [NumCnt-1:0] expired;

  logic [1:0]  valid_q, valid_d;
  logic [7:0]  tacho_q, tacho_d;
  logic [7:0]  dir_q, dir_d;
  logic [7:0]  wheel_q, wheel_d;
  logic [7:0]  brake_q, brake_d;
  logic [7:0]  accel_q, accel_d;
  logic [15:0] rpm_q, rpm_d;
  logic [31:0] long_q [NumLong];
  logic [31:0] long_d [NumLong];
  logic [15:0] short_q [NumShort];
  logic [15:0] short_d [NumShort];

  logic        out_valid_q;
  logic        unknown_q;
  logic [31:0] value_q;
  logic [31:0] rd_value;
  logic [4:0]  long_off, short_off;

  // Execute a transaction whenever the output register is free or drains.
  assign go        = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = go;
  assign do_frame  = go && (cmd_i.op == cansd_pkg::OP_FRAME);
  assign do_tick   = go && (cmd_i.op == cansd_pkg::OP_TICK);
  assign p         = cmd_i.payload;
  assign slot      = cmd_i.slot;

  // Staleness counters: a tick advances all, a frame clears its own.
  always_comb begin
    logic [7:0] inc;
    logic [7:0] lim;
    for (int c = 0; c < NumCnt; c++) begin
      inc = cnt_q[c] + 8'd1;
      lim = cansd_pkg::uses_long_limit(SlotW'(c)) ?
            long_timeout_i : short_timeout_i;
      expired[c] = do_tick && (inc == lim);
      cnt_d[c]   = cnt_q[c];
      if (do_tick) begin
        cnt_d[c] = expired[c] ? 8'd0 : inc;
      end
      if (do_frame && (slot == SlotW'(c))) begin
        cnt_d[c] = 8'd0;
      end
    end
  end

  // Signal registers: frames load them, expiry marks them invalid.
  always_comb begin
    valid_d = valid_q;
    tacho_d = tacho_q;
    dir_d   = dir_q;
    wheel_d = wheel_q;
    brake_d = brake_q;
    accel_d = accel_q;
    rpm_d   = rpm_q;
    long_d  = long_q;
    short_d = short_q;
    if (do_frame) begin
      case (slot)
        cansd_pkg::SLOT_TACHO: begin
          valid_d = valid_q | 2'b01;
          tacho_d = p[63:56];
          dir_d   = {6'd0, p[31:30]};
        end
        cansd_pkg::SLOT_WHEEL: begin
          valid_d = valid_q | 2'b10;
          wheel_d = p[23:16];
        end
        cansd_pkg::SLOT_ENGINE:  rpm_d   = p[39:24];
        cansd_pkg::SLOT_BRAKE:   brake_d = p[15:8];
        cansd_pkg::SLOT_ACCEL:   accel_d = p[15:8];
        cansd_pkg::SLOT_DIST: begin
          long_d[3] = p[63:32];
          long_d[2] = p[31:0];
        end
        cansd_pkg::SLOT_VDIST: begin
          long_d[0] = p[63:32];
          long_d[1] = p[31:0];
        end
        cansd_pkg::SLOT_FUEL: begin
          long_d[5] = p[63:32];
          long_d[4] = p[31:0];
        end
        cansd_pkg::SLOT_AMBIENT: short_d[0] = p[47:32];
        cansd_pkg::SLOT_HRDIST:  short_d[1] = p[15:0];
        cansd_pkg::SLOT_IDLE:    short_d[2] = p[15:0];
        cansd_pkg::SLOT_TEMP: begin
          short_d[3] = p[23:8];
          short_d[4] = p[39:24];
          short_d[5] = p[55:40];
        end
        default: ;
      endcase
    end
    if (expired[0]) begin
      valid_d = valid_d & 2'b10;
      dir_d   = '1;
    end
    if (expired[1]) valid_d = valid_d & 2'b01;
    if (expired[2]) rpm_d   = '1;
    if (expired[3]) brake_d = '1;
    if (expired[4]) accel_d = '1;
    if (expired[5]) begin
      long_d[2] = '1;
      long_d[3] = '1;
    end
    if (expired[6]) begin
      long_d[0] = '1;
      long_d[1] = '1;
    end
    if (expired[7]) begin
      long_d[4] = '1;
      long_d[5] = '1;
    end
    if (expired[8])  short_d[0] = '1;
    if (expired[9])  short_d[1] = '1;
    if (expired[10]) short_d[2] = '1;
    if (expired[11]) begin
      short_d[3] = '1;
      short_d[4] = '1;
      short_d[5] = '1;
    end
  end

  // Read selection from the current register contents.
  assign long_off  = cmd_i.sig_index - cansd_pkg::RD_LONG_FIRST;
  assign short_off = cmd_i.sig_index - cansd_pkg::RD_SHORT_FIRST;

  always_comb begin
    rd_value = '0;
    if (cmd_i.sig_index == cansd_pkg::RD_SPEED) begin
      if (valid_q == cansd_pkg::SPD_TACHO_ONLY) begin
        rd_value = {24'd0, tacho_q};
      end else if (valid_q == cansd_pkg::SPD_WHEEL_ONLY) begin
        rd_value = {24'd0, wheel_q};
      end else begin
        rd_value = 32'h0000_00FF;
      end
    end else if (cmd_i.sig_index == cansd_pkg::RD_DIRECTION) begin
      rd_value = {24'd0, dir_q};
    end else if (cmd_i.sig_index == cansd_pkg::RD_RPM) begin
      rd_value = {16'd0, rpm_q};
    end else if (cmd_i.sig_index == cansd_pkg::RD_BRAKE) begin
      rd_value = {24'd0, brake_q};
    end else if (cmd_i.sig_index == cansd_pkg::RD_ACCEL) begin
      rd_value = {24'd0, accel_q};
    end else if (cmd_i.sig_index == cansd_pkg::RD_VALID) begin
      rd_value = {30'd0, valid_q};
    end else if (cmd_i.sig_index >= cansd_pkg::RD_LONG_FIRST &&
                 cmd_i.sig_index <= cansd_pkg::RD_LONG_LAST) begin
      rd_value = long_q[long_off[2:0]];
    end else if (cmd_i.sig_index >= cansd_pkg::RD_SHORT_FIRST &&
                 cmd_i.sig_index <= cansd_pkg::RD_SHORT_LAST) begin
      rd_value = {16'd0, short_q[short_off[2:0]]};
    end
  end

  // State registers with their documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCnt; c++) begin
        cnt_q[c] <= '0;
      end
      for (int i = 0; i < NumLong; i++) begin
        long_q[i] <= '1;
      end
      for (int i = 0; i < NumShort; i++) begin
        short_q[i] <= '1;
      end
      valid_q <= '0;
      tacho_q <= '1;
      dir_q   <= '1;
      wheel_q <= '1;
      brake_q <= '1;
      accel_q <= '1;
      rpm_q   <= '1;
    end else begin
      cnt_q   <= cnt_d;
      long_q  <= long_d;
      short_q <= short_d;
      valid_q <= valid_d;
      tacho_q <= tacho_d;
      dir_q   <= dir_d;
      wheel_q <= wheel_d;
      brake_q <= brake_d;
      accel_q <= accel_d;
      rpm_q   <= rpm_d;
    end
  end

  // Output register holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      unknown_q <= (cmd_i.op == cansd_pkg::OP_UNKNOWN);
      value_q   <= (cmd_i.op == cansd_pkg::OP_READ) ? rd_value : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign unknown_group_o = unknown_q;
  assign read_value_o    = value_q;

endmodule

>>> hdl/cansd_checker.sv
module cansd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        unknown_group_o,
  input logic [31:0] read_value_o
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(unknown_group_o) && $stable(read_value_o))
    else $error("stalled result changed");

  // Only reads carry a value, so an unknown group always reports zero.
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unknown_group_o |-> read_value_o == 32'd0)
    else $error("unknown group result carries a value");

  // A cycle without an output stall drains the queue below full.
  a_no_stall_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(out_stall_i) |-> !in_stall_o)
    else $error("input stalled although the output drained");

endmodule

bind can_signal_decoder_with_timeouts cansd_checker u_cansd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .unknown_group_o (unknown_group_o),
  .read_value_o    (read_value_o)
);

>>> tb/can_signal_decoder_with_timeouts_test.sv
`timescale 1ns / 100ps

module can_signal_decoder_with_timeouts_test;

  // A kind other than frame, tick or read; the block must ignore it.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [7:0] ALL_ONES_8 = 8'hFF;

  // What one input transaction is expected to produce.
  typedef struct packed {
    logic        unknown;
    logic [31:0] value;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = cansd_pkg::KIND_TICK;
  logic [28:0] ext_id = '0;
  logic [63:0] payload = '0;
  logic [4:0]  signal_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        unknown_group;
  logic [31:0] read_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the decoder's registers, advanced on every accepted transaction.
  logic [7:0]  short_limit;
  logic [7:0]  long_limit;
  logic [1:0]  speed_valid;
  logic [7:0]  tacho_speed;
  logic [7:0]  travel_dir;
  logic [7:0]  wheel_spd;
  logic [7:0]  brake_pedal;
  logic [7:0]  accel_pedal;
  logic [15:0] engine_rpm;
  logic [31:0] long_sig [6];
  logic [15:0] short_sig [6];
  logic [7:0]  stale_cnt [12];

  decode_result_t pending_decodes[$];
  int unsigned mismatches = 0;
  bit          idling_on = 1'b1;
  int unsigned stall_left = 0;

  logic [15:0] known_pgns [13] = '{cansd_pkg::PGN_TACHO, cansd_pkg::PGN_WHEEL,
                                   cansd_pkg::PGN_ENGINE, cansd_pkg::PGN_BRAKE,
                                   cansd_pkg::PGN_ACCEL, cansd_pkg::PGN_DIST,
                                   cansd_pkg::PGN_VDIST, cansd_pkg::PGN_FUEL,
                                   cansd_pkg::PGN_AMBIENT, cansd_pkg::PGN_HRDIST,
                                   cansd_pkg::PGN_IDLE, cansd_pkg::PGN_TEMP,
                                   cansd_pkg::PGN_SILENT};

  can_signal_decoder_with_timeouts dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .ext_id_i       (ext_id),
    .payload_i      (payload),
    .signal_index_i (signal_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .unknown_group_o(unknown_group),
    .read_value_o   (read_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Bring the shadow registers to their state after reset.
  task automatic clear_signal_shadow();
    short_limit = cansd_pkg::SHORT_TIMEOUT_RST;
    long_limit  = cansd_pkg::LONG_TIMEOUT_RST;
    speed_valid = '0;
    tacho_speed = ALL_ONES_8;
    travel_dir  = ALL_ONES_8;
    wheel_spd   = ALL_ONES_8;
    brake_pedal = ALL_ONES_8;
    accel_pedal = ALL_ONES_8;
    engine_rpm  = '1;
    for (int i = 0; i < 6; i++) begin
      long_sig[i]  = '1;
      short_sig[i] = '1;
    end
    for (int i = 0; i < 12; i++) stale_cnt[i] = '0;
  endtask

  // Mark the signals behind one staleness counter as no longer valid.
  task automatic expire_counter(input int c);
    case (c)
      cansd_pkg::SLOT_TACHO: begin
        speed_valid[0] = 1'b0;
        travel_dir = ALL_ONES_8;
      end
      cansd_pkg::SLOT_WHEEL:   speed_valid[1] = 1'b0;
      cansd_pkg::SLOT_ENGINE:  engine_rpm = '1;
      cansd_pkg::SLOT_BRAKE:   brake_pedal = ALL_ONES_8;
      cansd_pkg::SLOT_ACCEL:   accel_pedal = ALL_ONES_8;
      cansd_pkg::SLOT_DIST: begin
        long_sig[2] = '1;
        long_sig[3] = '1;
      end
      cansd_pkg::SLOT_VDIST: begin
        long_sig[0] = '1;
        long_sig[1] = '1;
      end
      cansd_pkg::SLOT_FUEL: begin
        long_sig[4] = '1;
        long_sig[5] = '1;
      end
      cansd_pkg::SLOT_AMBIENT: short_sig[0] = '1;
      cansd_pkg::SLOT_HRDIST:  short_sig[1] = '1;
      cansd_pkg::SLOT_IDLE:    short_sig[2] = '1;
      default: begin
        short_sig[3] = '1;
        short_sig[4] = '1;
        short_sig[5] = '1;
      end
    endcase
  endtask

  // Apply one transaction to the shadow and work out the result it yields.
  task automatic track_signals(input logic [1:0] k, input logic [28:0] id,
                               input logic [63:0] pl, input logic [4:0] idx,
                               output decode_result_t res);
    logic [15:0] pgn;
    logic [7:0]  lim;
    logic [2:0]  off;
    pgn = id[23:8];
    res = '0;
    if (k == cansd_pkg::KIND_FRAME) begin
      case (pgn)
        cansd_pkg::PGN_TACHO: begin
          speed_valid[0] = 1'b1;
          tacho_speed = pl[63:56];
          travel_dir = {6'b0, pl[31:30]};
          stale_cnt[cansd_pkg::SLOT_TACHO] = '0;
        end
        cansd_pkg::PGN_WHEEL: begin
          speed_valid[1] = 1'b1;
          wheel_spd = pl[23:16];
          stale_cnt[cansd_pkg::SLOT_WHEEL] = '0;
        end
        cansd_pkg::PGN_ENGINE: begin
          engine_rpm = pl[39:24];
          stale_cnt[cansd_pkg::SLOT_ENGINE] = '0;
        end
        cansd_pkg::PGN_BRAKE: begin
          brake_pedal = pl[15:8];
          stale_cnt[cansd_pkg::SLOT_BRAKE] = '0;
        end
        cansd_pkg::PGN_ACCEL: begin
          accel_pedal = pl[15:8];
          stale_cnt[cansd_pkg::SLOT_ACCEL] = '0;
        end
        cansd_pkg::PGN_DIST: begin
          long_sig[3] = pl[63:32];
          long_sig[2] = pl[31:0];
          stale_cnt[cansd_pkg::SLOT_DIST] = '0;
        end
        cansd_pkg::PGN_VDIST: begin
          long_sig[0] = pl[63:32];
          long_sig[1] = pl[31:0];
          stale_cnt[cansd_pkg::SLOT_VDIST] = '0;
        end
        cansd_pkg::PGN_FUEL: begin
          long_sig[5] = pl[63:32];
          long_sig[4] = pl[31:0];
          stale_cnt[cansd_pkg::SLOT_FUEL] = '0;
        end
        cansd_pkg::PGN_AMBIENT: begin
          short_sig[0] = pl[47:32];
          stale_cnt[cansd_pkg::SLOT_AMBIENT] = '0;
        end
        cansd_pkg::PGN_HRDIST: begin
          short_sig[1] = pl[15:0];
          stale_cnt[cansd_pkg::SLOT_HRDIST] = '0;
        end
        cansd_pkg::PGN_IDLE: begin
          short_sig[2] = pl[15:0];
          stale_cnt[cansd_pkg::SLOT_IDLE] = '0;
        end
        cansd_pkg::PGN_TEMP: begin
          short_sig[3] = pl[23:8];
          short_sig[4] = pl[39:24];
          short_sig[5] = pl[55:40];
          stale_cnt[cansd_pkg::SLOT_TEMP] = '0;
        end
        cansd_pkg::PGN_SILENT: ;
        default: res.unknown = 1'b1;
      endcase
    end else if (k == cansd_pkg::KIND_TICK) begin
      // Every counter advances; distance and fuel run against the long limit.
      for (int c = 0; c < 12; c++) begin
        lim = (c >= cansd_pkg::SLOT_DIST && c <= cansd_pkg::SLOT_FUEL) ?
              long_limit : short_limit;
        stale_cnt[c] = stale_cnt[c] + 8'd1;
        if (stale_cnt[c] == lim) begin
          stale_cnt[c] = '0;
          expire_counter(c);
        end
      end
    end else if (k == cansd_pkg::KIND_READ) begin
      if (idx == cansd_pkg::RD_SPEED) begin
        if (speed_valid == cansd_pkg::SPD_TACHO_ONLY) res.value = {24'd0, tacho_speed};
        else if (speed_valid == cansd_pkg::SPD_WHEEL_ONLY) res.value = {24'd0, wheel_spd};
        else res.value = 32'hFF;
      end else if (idx == cansd_pkg::RD_DIRECTION) res.value = {24'd0, travel_dir};
      else if (idx == cansd_pkg::RD_RPM) res.value = {16'd0, engine_rpm};
      else if (idx == cansd_pkg::RD_BRAKE) res.value = {24'd0, brake_pedal};
      else if (idx == cansd_pkg::RD_ACCEL) res.value = {24'd0, accel_pedal};
      else if (idx == cansd_pkg::RD_VALID) res.value = {30'd0, speed_valid};
      else if (idx >= cansd_pkg::RD_LONG_FIRST && idx <= cansd_pkg::RD_LONG_LAST) begin
        off = 3'(idx - cansd_pkg::RD_LONG_FIRST);
        res.value = long_sig[off];
      end else if (idx >= cansd_pkg::RD_SHORT_FIRST && idx <= cansd_pkg::RD_SHORT_LAST) begin
        off = 3'(idx - cansd_pkg::RD_SHORT_FIRST);
        res.value = {16'd0, short_sig[off]};
      end
    end
  endtask

  // Offer one transaction and record its expected result once it is taken.
  task automatic send_item(input logic [1:0] k, input logic [28:0] id,
                           input logic [63:0] pl, input logic [4:0] idx);
    decode_result_t res;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    ext_id = id;
    payload = pl;
    signal_index = idx;
    do @(posedge clk); while (in_stall);
    track_signals(k, id, pl, idx, res);
    pending_decodes.push_back(res);
  endtask

  // Frame of a given group with random priority and source address bits.
  task automatic send_frame(input logic [15:0] pgn, input logic [63:0] pl);
    logic [31:0] r;
    r = $urandom;
    send_item(cansd_pkg::KIND_FRAME, {r[4:0], pgn, r[15:8]}, pl, r[20:16]);
  endtask

  task automatic send_read(input logic [4:0] idx);
    send_item(cansd_pkg::KIND_READ, 29'($urandom), {$urandom, $urandom}, idx);
  endtask

  // Stop offering transactions and wait for every result to come out.
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one timeout register over APB and read it back.
  task automatic set_timeout(input logic reg_sel, input logic [7:0] ticks);
    settle_block();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 2'b00};
    pwdata = {24'b0, ticks};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== ticks)
      report_mismatch($sformatf("timeout register %0d reads %0h, wrote %0h",
                                reg_sel, prdata[7:0], ticks));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (reg_sel == cansd_pkg::CFG_SHORT) short_limit = ticks;
    else long_limit = ticks;
  endtask

  // Mixed traffic: mostly well-formed frames of known groups, ticks and reads.
  task automatic run_mixed_traffic(input int unsigned n, input int unsigned tick_pct);
    int unsigned r;
    logic [4:0]  idx;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      idx = 5'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 17)
                                            : $urandom_range(18, 31));
      if (r < tick_pct) begin
        send_item(cansd_pkg::KIND_TICK, 29'($urandom), {$urandom, $urandom}, idx);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 42) send_frame(known_pgns[4'($urandom_range(0, 12))],
                               {$urandom, $urandom});
        else if (r < 50) send_frame(16'($urandom), {$urandom, $urandom});
        else if (r < 97) send_read(idx);
        else send_item(KIND_SPARE, 29'($urandom), {$urandom, $urandom}, idx);
      end
    end
  endtask

  task automatic test_power_on_values();
    send_read(cansd_pkg::RD_SPEED);
    send_read(cansd_pkg::RD_DIRECTION);
    send_read(cansd_pkg::RD_RPM);
    send_read(cansd_pkg::RD_VALID);
    send_read(cansd_pkg::RD_LONG_LAST);
    send_read(cansd_pkg::RD_SHORT_LAST);
    send_read(cansd_pkg::RD_SHORT_LAST + 5'd1);
    send_read(5'd31);
  endtask

  // One frame per known group, an undecoded group and the spare kind.
  task automatic test_group_decoding();
    send_frame(cansd_pkg::PGN_TACHO, '1);
    send_frame(cansd_pkg::PGN_WHEEL, '0);
    for (int i = 2; i < 13; i++) send_frame(known_pgns[i], {$urandom, $urandom});
    send_item(cansd_pkg::KIND_FRAME, '1, '1, '1);
    send_item(KIND_SPARE, '1, '1, '1);
    send_read(cansd_pkg::RD_SPEED);
    send_read(cansd_pkg::RD_DIRECTION);
  endtask

  task automatic test_default_timeouts();
    run_mixed_traffic(200, 30);
  endtask

  // Extreme limits; raising and lowering them leaves counters above the limit.
  task automatic test_extreme_timeouts();
    set_timeout(cansd_pkg::CFG_SHORT, 8'd1);
    set_timeout(cansd_pkg::CFG_LONG, 8'd255);
    run_mixed_traffic(150, 40);
    set_timeout(cansd_pkg::CFG_SHORT, 8'd255);
    set_timeout(cansd_pkg::CFG_LONG, 8'd1);
    run_mixed_traffic(150, 40);
  endtask

  // A zero limit only matches after the counter wraps, so frames stay rare.
  task automatic test_zero_timeouts();
    set_timeout(cansd_pkg::CFG_SHORT, 8'd0);
    set_timeout(cansd_pkg::CFG_LONG, 8'd0);
    run_mixed_traffic(320, 90);
  endtask

  task automatic test_full_rate();
    set_timeout(cansd_pkg::CFG_SHORT, 8'd3);
    set_timeout(cansd_pkg::CFG_LONG, 8'd7);
    idling_on = 1'b0;
    run_mixed_traffic(150, 35);
  endtask

  // Receiver stalls in short bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin
    decode_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_decodes.pop_front();
        if (unknown_group !== want.unknown)
          report_mismatch($sformatf("unknown_group %b, expected %b",
                                    unknown_group, want.unknown));
        if (read_value !== want.value)
          report_mismatch($sformatf("read_value %0h, expected %0h",
                                    read_value, want.value));
      end
    end
  end

  initial begin
    clear_signal_shadow();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_power_on_values();
    test_group_decoding();
    test_default_timeouts();
    test_extreme_timeouts();
    test_zero_timeouts();
    test_full_rate();
    settle_block();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("can_signal_decoder_with_timeouts_test: done, clean");
    end else begin
      $display("can_signal_decoder_with_timeouts_test: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("%0t ns: timeout with %0d results outstanding", $time, pending_decodes.size());
    $display("can_signal_decoder_with_timeouts_test: done, errors");
    $finish;
  end

endmodule
